// File: sv/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Each macro takes a label, the clock, the active-low reset, the
// condition(s) and the message reported on failure.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define DWMB_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DWMB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/dwmb_pkg.sv
`timescale 1ns / 1ps

package dwmb_pkg;

  // Field and datapath widths.
  localparam int COORD_W    = 12;
  localparam int DEPTH_W    = 16;
  localparam int CFG_W      = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int SUM_W      = 26;
  localparam int COUNT_W    = 10;
  localparam int MEAN_W     = 20;
  localparam int BEARING_W  = 15;
  localparam int NUM_W      = 30;
  localparam int XY_W       = 34;
  localparam int Z_W        = 24;
  localparam int ANGLE_W    = 21;
  localparam int STEP_W     = 5;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  // Bit positions inside the stream words.
  localparam int IN_COL_LSB      = 0;
  localparam int IN_ROW_LSB      = 12;
  localparam int IN_DEPTH_LSB    = 24;
  localparam int OUT_MEAN_LSB    = 0;
  localparam int OUT_BEARING_LSB = 20;
  localparam int OUT_COUNT_LSB   = 35;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_COL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_ROW = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DEPTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DEPTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PRINCIPAL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL      = 3'd5;

  // Register values after reset.
  localparam logic [DEPTH_W-1:0] MIN_DEPTH_RST = 16'd300;
  localparam logic [DEPTH_W-1:0] MAX_DEPTH_RST = 16'd3000;
  localparam logic [CFG_W-1:0]   PRINCIPAL_RST = 20'd84360;
  localparam logic [CFG_W-1:0]   FOCAL_RST     = 20'd154192;

  // Sequencer limits and angle constants.
  localparam logic [COUNT_W-1:0]   COUNT_MAX   = 10'd1023;
  localparam logic [STEP_W-1:0]    DIV_LAST    = 5'd29;
  localparam logic [STEP_W-1:0]    CORDIC_LAST = 5'd17;
  localparam logic [ANGLE_W-1:0]   RIGHT_ANGLE = 21'd1474560;
  localparam logic [BEARING_W-1:0] STRAIGHT_Q7 = 15'd23040;

  typedef enum logic [1:0] {
    ST_ACC,
    ST_DIV,
    ST_CORDIC,
    ST_LOAD
  } state_t;

  // Arctangent of 2^-i in 1/16384 degree.
  function automatic logic [ANGLE_W-2:0] atan_q14(input logic [STEP_W-1:0] i);
    logic [ANGLE_W-2:0] a;
    case (i)
      5'd0:    a = 20'd737280;
      5'd1:    a = 20'd435242;
      5'd2:    a = 20'd229970;
      5'd3:    a = 20'd116736;
      5'd4:    a = 20'd58595;
      5'd5:    a = 20'd29326;
      5'd6:    a = 20'd14667;
      5'd7:    a = 20'd7334;
      5'd8:    a = 20'd3667;
      5'd9:    a = 20'd1833;
      5'd10:   a = 20'd917;
      5'd11:   a = 20'd458;
      5'd12:   a = 20'd229;
      5'd13:   a = 20'd115;
      5'd14:   a = 20'd57;
      5'd15:   a = 20'd29;
      5'd16:   a = 20'd14;
      5'd17:   a = 20'd7;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// File: sv/depth_window_mean_and_bearing_core.sv
// Depth window mean and bearing.
// The in_ channel carries one depth pixel per request (column, row, depth in mm);
// in_tlast marks the final pixel of a frame. Pixels inside the square window
// around the configured centre whose depth lies within [min, max] are summed
// and counted, and the depth at the centre pixel is captured.
// Pixels without tlast are taken at one per clock. The last pixel of a frame
// holds in_tready low while the one-bit-a-cycle restoring divider forms the
// mean, 18 iterations of the shared CORDIC stage form the bearing and the
// result is loaded into the output register. The load waits until the output
// register is free, and the result then appears on out_ from that register.
// One result request per frame: mean in 1/16 mm, bearing in 1/128 degree,
// count, and window_valid on out_tuser. The output register holds a stalled
// result; the next frame's pixels are still taken meanwhile, and a following
// result waits in the load cycle until the register is free.
// Configuration is to be written through cfg_we/cfg_index/cfg_data only while
// idle; the block itself does not enforce this. Synchronous reset clears the
// accumulators and output valid and sets registers to their defaults.
`timescale 1ns / 1ps

module depth_window_mean_and_bearing_core #(
  parameter int WINDOW_MARGIN = 15,
  parameter int COORD_BITS    = 12
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // pixel_col[11:0], pixel_row[23:12], depth_mm[39:24]
  input  logic [dwmb_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // mean_depth_q4[19:0], bearing_q7[34:20], valid_count[44:35], zero[47:45]
  output logic [dwmb_pkg::OUT_DATA_W-1:0]    out_tdata,
  // window_valid[0]
  output logic                               out_tuser,
  input  logic                               cfg_we,
  input  logic [dwmb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dwmb_pkg::CFG_W-1:0]         cfg_data
);

  localparam int CoordW  = dwmb_pkg::COORD_W;
  localparam int DepthW  = dwmb_pkg::DEPTH_W;
  localparam int SumW    = dwmb_pkg::SUM_W;
  localparam int CountW  = dwmb_pkg::COUNT_W;
  localparam int NumW    = dwmb_pkg::NUM_W;
  localparam int XyW     = dwmb_pkg::XY_W;
  localparam int ZW      = dwmb_pkg::Z_W;
  localparam int AngleW  = dwmb_pkg::ANGLE_W;
  localparam int StepW   = dwmb_pkg::STEP_W;
  localparam int MeanW   = dwmb_pkg::MEAN_W;
  localparam int BearW   = dwmb_pkg::BEARING_W;
  localparam int CfgW    = dwmb_pkg::CFG_W;
  localparam int WinW    = CoordW + 1;
  localparam logic [CoordW-1:0] CoordMask = CoordW'((1 << COORD_BITS) - 1);
  localparam logic [WinW-1:0]   Margin    = WinW'(WINDOW_MARGIN);

  // Configuration registers.
  logic [CoordW-1:0] center_col_r, center_row_r;
  logic [DepthW-1:0] min_depth_r, max_depth_r;
  logic [CfgW-1:0]   principal_r, focal_r;

  // Accumulators.
  logic [SumW-1:0]   sum_r, sum_upd;
  logic [CountW-1:0] cnt_r, cnt_upd;
  logic [DepthW-1:0] cdepth_r, cdepth_upd;

  // Sequencer.
  dwmb_pkg::state_t  state_r, state_nxt;
  logic [StepW-1:0]  step_r, step_nxt;
  logic              div_run, cordic_run, load_out;

  // Divider and CORDIC working registers.
  logic [NumW-1:0]          num_r;
  logic [CountW:0]          rem_r;
  logic [CountW-1:0]        div_r;
  logic signed [XyW-1:0]    x_r, y_r;
  logic signed [ZW-1:0]     z_r;
  logic                     neg_r, cnz_r;

  // Output register.
  logic              out_valid_r;
  logic [MeanW-1:0]  mean_o_r;
  logic [BearW-1:0]  bear_o_r;
  logic [CountW-1:0] count_o_r;
  logic              wvalid_o_r;

  // Pixel decode and window test.
  logic [CoordW-1:0] pix_col, pix_row, cc, cr;
  logic [DepthW-1:0] depth;
  logic              pix_acc, in_win, at_center, take;

  assign pix_col = in_tdata[dwmb_pkg::IN_COL_LSB +: CoordW] & CoordMask;
  assign pix_row = in_tdata[dwmb_pkg::IN_ROW_LSB +: CoordW] & CoordMask;
  assign depth   = in_tdata[dwmb_pkg::IN_DEPTH_LSB +: DepthW];
  assign cc      = center_col_r & CoordMask;
  assign cr      = center_row_r & CoordMask;
  assign pix_acc = in_tvalid && in_tready;

  assign in_win = ({1'b0, pix_col} + Margin >= {1'b0, cc}) &&
                  ({1'b0, pix_col} < {1'b0, cc} + Margin) &&
                  ({1'b0, pix_row} + Margin >= {1'b0, cr}) &&
                  ({1'b0, pix_row} < {1'b0, cr} + Margin);
  assign at_center = (pix_col == cc) && (pix_row == cr);
  assign take = in_win && (depth >= min_depth_r) && (depth <= max_depth_r) &&
                (cnt_r != dwmb_pkg::COUNT_MAX);

  // Accumulator values including the current pixel.
  assign sum_upd    = take ? sum_r + {{(SumW - DepthW){1'b0}}, depth} : sum_r;
  assign cnt_upd    = take ? cnt_r + {{(CountW - 1){1'b0}}, 1'b1} : cnt_r;
  assign cdepth_upd = at_center ? depth : cdepth_r;

  // Dividend with rounding term, and the signed column offset.
  logic [NumW-1:0]   num_init;
  logic [AngleW-1:0] dx, dx_abs;
  logic              dx_neg;

  assign num_init = {sum_upd, 4'b0000} +
                    {{(NumW - CountW + 1){1'b0}}, cnt_upd[CountW-1:1]};
  assign dx       = {1'b0, cc, 8'h00} - {1'b0, principal_r};
  assign dx_neg   = dx[AngleW-1];
  assign dx_abs   = dx_neg ? (~dx + {{(AngleW - 1){1'b0}}, 1'b1}) : dx;

  // One restoring divide step.
  logic [CountW:0]   rem_shift;
  logic [CountW+1:0] rem_diff;
  logic              rem_ge;

  assign rem_shift = {rem_r[CountW-1:0], num_r[NumW-1]};
  assign rem_diff  = {1'b0, rem_shift} - {2'b00, div_r};
  assign rem_ge    = !rem_diff[CountW+1];

  // One CORDIC vectoring step.
  logic signed [XyW-1:0] xs, ys;
  logic signed [ZW-1:0]  atan_s;

  assign xs     = x_r >>> step_r;
  assign ys     = y_r >>> step_r;
  assign atan_s = signed'({{(ZW - AngleW + 1){1'b0}}, dwmb_pkg::atan_q14(step_r)});

  // Angle clamp, rounding and side selection.
  logic [AngleW-1:0] z_clamp;
  logic [AngleW:0]   q_sum;
  logic [BearW-1:0]  q_deg, bearing;

  always_comb begin
    if (z_r[ZW-1]) begin
      z_clamp = '0;
    end else if (z_r[ZW-2:0] > {{(ZW - 1 - AngleW){1'b0}}, dwmb_pkg::RIGHT_ANGLE}) begin
      z_clamp = dwmb_pkg::RIGHT_ANGLE;
    end else begin
      z_clamp = z_r[AngleW-1:0];
    end
  end

  assign q_sum   = {1'b0, z_clamp} + (AngleW + 1)'(64);
  assign q_deg   = q_sum[AngleW:7];
  assign bearing = !cnz_r ? '0 :
                   neg_r ? dwmb_pkg::STRAIGHT_Q7 - q_deg : q_deg;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dwmb_pkg::ST_ACC: begin
        if (pix_acc && in_tlast) state_nxt = dwmb_pkg::ST_DIV;
      end
      dwmb_pkg::ST_DIV: begin
        if (step_r == dwmb_pkg::DIV_LAST) state_nxt = dwmb_pkg::ST_CORDIC;
      end
      dwmb_pkg::ST_CORDIC: begin
        if (step_r == dwmb_pkg::CORDIC_LAST) state_nxt = dwmb_pkg::ST_LOAD;
      end
      dwmb_pkg::ST_LOAD: begin
        if (!out_valid_r || out_tready) state_nxt = dwmb_pkg::ST_ACC;
      end
      default: state_nxt = dwmb_pkg::ST_ACC;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_tready  = 1'b0;
    div_run    = 1'b0;
    cordic_run = 1'b0;
    load_out   = 1'b0;
    unique case (state_r)
      dwmb_pkg::ST_ACC:    in_tready  = 1'b1;
      dwmb_pkg::ST_DIV:    div_run    = 1'b1;
      dwmb_pkg::ST_CORDIC: cordic_run = 1'b1;
      dwmb_pkg::ST_LOAD:   load_out   = !out_valid_r || out_tready;
      default:             in_tready  = 1'b0;
    endcase
  end

  // Step counter shared by the divider and the CORDIC stage.
  always_comb begin
    step_nxt = '0;
    if ((div_run && step_r != dwmb_pkg::DIV_LAST) ||
        (cordic_run && step_r != dwmb_pkg::CORDIC_LAST)) begin
      step_nxt = step_r + {{(StepW - 1){1'b0}}, 1'b1};
    end
  end

  // Control state, accumulators and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= dwmb_pkg::ST_ACC;
      step_r       <= '0;
      sum_r        <= '0;
      cnt_r        <= '0;
      cdepth_r     <= '0;
      out_valid_r  <= 1'b0;
      center_col_r <= '0;
      center_row_r <= '0;
      min_depth_r  <= dwmb_pkg::MIN_DEPTH_RST;
      max_depth_r  <= dwmb_pkg::MAX_DEPTH_RST;
      principal_r  <= dwmb_pkg::PRINCIPAL_RST;
      focal_r      <= dwmb_pkg::FOCAL_RST;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (pix_acc) begin
        if (in_tlast) begin
          sum_r    <= '0;
          cnt_r    <= '0;
          cdepth_r <= '0;
        end else begin
          sum_r    <= sum_upd;
          cnt_r    <= cnt_upd;
          cdepth_r <= cdepth_upd;
        end
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          dwmb_pkg::REG_CENTER_COL: center_col_r <= cfg_data[CoordW-1:0];
          dwmb_pkg::REG_CENTER_ROW: center_row_r <= cfg_data[CoordW-1:0];
          dwmb_pkg::REG_MIN_DEPTH:  min_depth_r  <= cfg_data[DepthW-1:0];
          dwmb_pkg::REG_MAX_DEPTH:  max_depth_r  <= cfg_data[DepthW-1:0];
          dwmb_pkg::REG_PRINCIPAL:  principal_r  <= cfg_data;
          dwmb_pkg::REG_FOCAL:      focal_r      <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Divider and CORDIC datapath; loaded when the last pixel arrives.
  always_ff @(posedge clk) begin
    if (pix_acc && in_tlast) begin
      num_r <= num_init;
      rem_r <= '0;
      div_r <= cnt_upd;
      x_r   <= signed'({{(XyW - AngleW - 9){1'b0}}, dx_abs[AngleW-2:0], 10'b0});
      y_r   <= signed'({{(XyW - CfgW - 10){1'b0}}, focal_r, 10'b0});
      z_r   <= '0;
      neg_r <= dx_neg;
      cnz_r <= (cdepth_upd != '0);
    end else if (div_run) begin
      num_r <= {num_r[NumW-2:0], rem_ge};
      rem_r <= rem_ge ? rem_diff[CountW:0] : rem_shift;
    end else if (cordic_run) begin
      if (!y_r[XyW-1]) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + atan_s;
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - atan_s;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (load_out) begin
      mean_o_r   <= (div_r == '0) ? '0 : num_r[MeanW-1:0];
      bear_o_r   <= bearing;
      count_o_r  <= div_r;
      wvalid_o_r <= (div_r != '0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, count_o_r, bear_o_r, mean_o_r};
  assign out_tuser  = wvalid_o_r;

endmodule

// File: sv/dwmb_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dwmb_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            in_tlast,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [dwmb_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            out_tuser
);

  localparam int CountW = dwmb_pkg::COUNT_W;
  localparam int MeanW  = dwmb_pkg::MEAN_W;
  localparam int BearW  = dwmb_pkg::BEARING_W;

  // A stalled result keeps its value.
  `DWMB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  // The end of a frame starts the result computation and holds the input off.
  `DWMB_ASSERT_NEXT(a_busy_after_last, clk, rst_n, in_tvalid && in_tready && in_tlast, !in_tready, "input ready right after last pixel")

  // The valid flag agrees with the count.
  `DWMB_ASSERT_IMPLY(a_valid_count, clk, rst_n, out_tvalid, out_tuser == (out_tdata[dwmb_pkg::OUT_COUNT_LSB +: CountW] != '0), "window flag and count disagree")

  // An empty window gives a zero mean.
  `DWMB_ASSERT_IMPLY(a_empty_mean, clk, rst_n, out_tvalid && !out_tuser, out_tdata[dwmb_pkg::OUT_MEAN_LSB +: MeanW] == '0, "empty window with nonzero mean")

  // The bearing never exceeds a straight angle.
  `DWMB_ASSERT_IMPLY(a_bearing_range, clk, rst_n, out_tvalid, out_tdata[dwmb_pkg::OUT_BEARING_LSB +: BearW] <= dwmb_pkg::STRAIGHT_Q7, "bearing above 180 degrees")

endmodule

bind depth_window_mean_and_bearing_core dwmb_checker u_dwmb_checker (.*);
